@@ sv/cpts_pkg.sv @@
// shared types, constants and helpers of the counter and priority task scheduler
package cpts_pkg;

  localparam int unsigned TASK_SLOTS_DEF = 64;
  localparam int unsigned SLOT_W_DEF     = $clog2(TASK_SLOTS_DEF);
  localparam int unsigned KIND_W         = 3;
  localparam int unsigned IN_SLOT_W      = 6;
  localparam int unsigned OUT_SLOT_W     = 6;
  localparam int unsigned PRIO_W         = 7;
  localparam int unsigned CNT_W          = 8;
  localparam int unsigned DEPTH_W        = 4;
  localparam logic [DEPTH_W-1:0] DEPTH_MAX = 4'd15;

  typedef enum logic [KIND_W-1:0] {
    KIND_TICK  = 3'd0,
    KIND_YIELD = 3'd1,
    KIND_SET   = 3'd2,
    KIND_PDIS  = 3'd3,
    KIND_PEN   = 3'd4
  } kind_e;

  // one task slot as held in the slot memory
  typedef struct packed {
    logic               present;
    logic               ready;
    logic [PRIO_W-1:0]  prio;
    logic [CNT_W-1:0]   cnt;
    logic [DEPTH_W-1:0] depth;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  // control of the best-slot search unit
  typedef struct packed {
    logic             clear;
    logic             sample;
    logic             eligible;
    logic [CNT_W-1:0] count;
  } pick_ctl_t;

  typedef struct packed {
    logic             found;
    logic [CNT_W-1:0] best;
  } pick_res_t;

  // value of a slot that has not been written since reset
  function automatic entry_t reset_entry(input logic slot_zero);
    entry_t e;
    e = '0;
    if (slot_zero) begin
      e.present = 1'b1;
      e.ready   = 1'b1;
      e.prio    = PRIO_W'(1);
    end
    return e;
  endfunction

endpackage

@@ sv/cpts_ram.sv @@
// generic simple dual port ram with registered read
module cpts_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/cpts_pick.sv @@
// running search for the eligible slot with the largest counter, lowest index on ties
module cpts_pick import cpts_pkg::*; #(
  parameter int unsigned IDX_W = SLOT_W_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  pick_ctl_t        ctl_i,
  input  logic [IDX_W-1:0] idx_i,
  output pick_res_t        res_o,
  output logic [IDX_W-1:0] idx_o
);

  logic             found_q, found_d;
  logic [CNT_W-1:0] best_q, best_d;
  logic [IDX_W-1:0] idx_q, idx_d;

  always_comb begin
    found_d = found_q;
    best_d  = best_q;
    idx_d   = idx_q;
    if (ctl_i.clear) begin
      found_d = 1'b0;
      best_d  = '0;
      idx_d   = '0;
    end else if (ctl_i.sample && ctl_i.eligible && (!found_q || ctl_i.count > best_q)) begin
      // strictly greater keeps the earlier slot on a tie
      found_d = 1'b1;
      best_d  = ctl_i.count;
      idx_d   = idx_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
      best_q  <= '0;
      idx_q   <= '0;
    end else begin
      found_q <= found_d;
      best_q  <= best_d;
      idx_q   <= idx_d;
    end
  end

  assign res_o.found = found_q;
  assign res_o.best  = best_q;
  assign idx_o       = idx_q;

endmodule

@@ sv/counter_priority_task_scheduler.sv @@
// top level of the counter and priority task scheduler
//
// input channel: one beat per scheduler event (tick, yield, set task slot,
// preempt disable, preempt enable); kind_i selects, the other fields are used
// by set task only. output channel: one beat per input beat, carrying the
// current slot, its counter and the switched / scheduled / refilled / stuck
// flags.
// the slot table lives in one memory with a registered read; every known event
// on an in range slot is a read, modify and write back of one slot, followed by a
// read of the current slot for the result; other beats only do that last read.
// a reschedule adds a search sweep over all TASK_SLOTS slots and, when every
// ready counter is zero, a refill sweep over them all as well. one event is in
// work at a time and the next beat is taken the cycle after the result is loaded.
// reset: slot zero is present, ready, priority one and current; all other
// slots read as empty through per-slot written flags, so no clearing pass.
// a finished result sits in the output register; the next beat is taken while
// it waits, and that beat stalls before its own result if the receiver is slow.
module counter_priority_task_scheduler import cpts_pkg::*; #(
  parameter int unsigned TASK_SLOTS = TASK_SLOTS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [KIND_W-1:0]     kind_i,
  input  logic [IN_SLOT_W-1:0]  slot_i,
  input  logic                  present_i,
  input  logic                  runnable_i,
  input  logic [PRIO_W-1:0]     priority_req_i,
  input  logic [CNT_W-1:0]      counter_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [OUT_SLOT_W-1:0] current_slot_o,
  output logic                  switched_o,
  output logic                  scheduled_o,
  output logic                  refilled_o,
  output logic                  stuck_o,
  output logic [CNT_W-1:0]      current_counter_o
);

  localparam int unsigned SLOT_W = $clog2(TASK_SLOTS);
  localparam logic [SLOT_W:0] SCAN_END = TASK_SLOTS[SLOT_W:0];

  typedef enum logic [7:0] {
    ST_IDLE   = 8'b0000_0001,
    ST_FETCH  = 8'b0000_0010,
    ST_MOD    = 8'b0000_0100,
    ST_SCAN   = 8'b0000_1000,
    ST_DECIDE = 8'b0001_0000,
    ST_REFILL = 8'b0010_0000,
    ST_RPT_RD = 8'b0100_0000,
    ST_RPT    = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  // latched input beat
  logic [KIND_W-1:0]    kind_q;
  logic [IN_SLOT_W-1:0] slot_q;
  logic                 present_q, runnable_q;
  logic [PRIO_W-1:0]    prio_q;
  logic [CNT_W-1:0]     cnt_q;

  // scheduler state outside the memory
  logic [SLOT_W-1:0]     cur_q, cur_d;
  logic [TASK_SLOTS-1:0] written_q;

  // result flags of the beat in work
  logic sched_q, sched_d, sw_q, sw_d, refl_q, refl_d, stuck_q, stuck_d;

  // sweep address and read pipeline tracking
  logic [SLOT_W:0]   scan_addr_q, scan_addr_d;
  logic              pend_q, pend_d;
  logic [SLOT_W-1:0] rd_idx_q;
  logic              rd_written_q;

  // memory port signals
  logic              ram_we, ram_re;
  logic [SLOT_W-1:0] ram_waddr, ram_raddr;
  entry_t            ram_wdata;
  logic [ENTRY_W-1:0] ram_rdata;

  // search unit
  pick_ctl_t         pick_ctl;
  pick_res_t         pick_res;
  logic [SLOT_W-1:0] pick_idx;

  // output register
  logic                  out_valid_q, out_valid_d;
  logic [OUT_SLOT_W-1:0] out_slot_q;
  logic                  out_sw_q, out_sched_q, out_refl_q, out_stuck_q;
  logic [CNT_W-1:0]      out_cnt_q;
  logic                  out_load;

  // slot read back, never-written slots take their reset value
  entry_t           ent_rd;
  entry_t           ent_new;
  logic [CNT_W-1:0] refill_cnt;
  logic             slot_in_range;
  logic             issue;

  cpts_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TASK_SLOTS)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  cpts_pick #(
    .IDX_W (SLOT_W)
  ) u_pick (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (pick_ctl),
    .idx_i  (rd_idx_q),
    .res_o  (pick_res),
    .idx_o  (pick_idx)
  );

  assign ent_rd        = rd_written_q ? entry_t'(ram_rdata) : reset_entry(rd_idx_q == '0);
  assign refill_cnt    = (ent_rd.cnt >> 1) + CNT_W'(ent_rd.prio);
  assign slot_in_range = 32'(slot_q) < TASK_SLOTS;
  assign issue         = (scan_addr_q != SCAN_END);
  assign in_ready_o    = (state_q == ST_IDLE);

  always_comb begin
    state_d     = state_q;
    cur_d       = cur_q;
    sched_d     = sched_q;
    sw_d        = sw_q;
    refl_d      = refl_q;
    stuck_d     = stuck_q;
    scan_addr_d = scan_addr_q;
    pend_d      = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = rd_idx_q;
    ram_wdata   = ent_rd;
    ram_re      = 1'b0;
    ram_raddr   = cur_q;
    pick_ctl    = '0;
    ent_new     = ent_rd;
    out_load    = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          sched_d = 1'b0;
          sw_d    = 1'b0;
          refl_d  = 1'b0;
          stuck_d = 1'b0;
          state_d = ST_FETCH;
        end
      end

      ST_FETCH: begin
        unique case (kind_e'(kind_q))
          KIND_TICK, KIND_YIELD, KIND_PDIS, KIND_PEN: begin
            ram_re  = 1'b1;
            state_d = ST_MOD;
          end
          KIND_SET: begin
            if (slot_in_range) begin
              ram_re    = 1'b1;
              ram_raddr = SLOT_W'(slot_q);
              state_d   = ST_MOD;
            end else begin
              state_d = ST_RPT_RD;
            end
          end
          default: state_d = ST_RPT_RD;
        endcase
      end

      ST_MOD: begin
        ram_we  = 1'b1;
        state_d = ST_RPT_RD;
        unique case (kind_e'(kind_q))
          KIND_TICK: begin
            // counter saturates at zero
            if (ent_rd.cnt != '0) begin
              ent_new.cnt = ent_rd.cnt - CNT_W'(1);
            end
            if (ent_new.cnt == '0 && ent_rd.depth == '0) begin
              sched_d = 1'b1;
            end
          end
          KIND_YIELD: begin
            ent_new.cnt = '0;
            sched_d     = 1'b1;
          end
          KIND_SET: begin
            // preemption depth of the slot is kept
            ent_new.present = present_q;
            ent_new.ready   = runnable_q;
            ent_new.prio    = prio_q;
            ent_new.cnt     = cnt_q;
          end
          KIND_PDIS: begin
            if (ent_rd.depth != DEPTH_MAX) begin
              ent_new.depth = ent_rd.depth + DEPTH_W'(1);
            end
          end
          KIND_PEN: begin
            if (ent_rd.depth != '0) begin
              ent_new.depth = ent_rd.depth - DEPTH_W'(1);
            end
          end
          default: ram_we = 1'b0;
        endcase
        ram_wdata = ent_new;
        if (sched_d) begin
          scan_addr_d    = '0;
          pick_ctl.clear = 1'b1;
          state_d        = ST_SCAN;
        end
      end

      ST_SCAN, ST_REFILL: begin
        // one read issued per cycle, its data examined the cycle after
        if (issue) begin
          ram_re      = 1'b1;
          ram_raddr   = scan_addr_q[SLOT_W-1:0];
          scan_addr_d = scan_addr_q + (SLOT_W+1)'(1);
          pend_d      = 1'b1;
        end
        if (state_q == ST_REFILL && ent_rd.present) begin
          ent_new.cnt = refill_cnt;
          ram_we      = pend_q;
          ram_wdata   = ent_new;
        end
        pick_ctl.sample   = pend_q;
        pick_ctl.eligible = ent_new.present && ent_new.ready;
        pick_ctl.count    = ent_new.cnt;
        if (!issue && !pend_q) begin
          state_d = ST_DECIDE;
        end
      end

      ST_DECIDE: begin
        state_d = ST_RPT_RD;
        if (refl_q) begin
          stuck_d = (pick_res.best == '0);
          sw_d    = (pick_idx != cur_q);
          cur_d   = pick_idx;
        end else if (!pick_res.found) begin
          // nothing ready: fall back to slot zero
          sw_d  = (cur_q != '0);
          cur_d = '0;
        end else if (pick_res.best == '0) begin
          refl_d         = 1'b1;
          scan_addr_d    = '0;
          pick_ctl.clear = 1'b1;
          state_d        = ST_REFILL;
        end else begin
          sw_d  = (pick_idx != cur_q);
          cur_d = pick_idx;
        end
      end

      ST_RPT_RD: begin
        ram_re  = 1'b1;
        state_d = ST_RPT;
      end

      ST_RPT: begin
        // wait here while the previous result is still unclaimed
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  assign out_valid_d = out_load || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      cur_q        <= '0;
      written_q    <= '0;
      sched_q      <= 1'b0;
      sw_q         <= 1'b0;
      refl_q       <= 1'b0;
      stuck_q      <= 1'b0;
      scan_addr_q  <= '0;
      pend_q       <= 1'b0;
      rd_idx_q     <= '0;
      rd_written_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      cur_q       <= cur_d;
      sched_q     <= sched_d;
      sw_q        <= sw_d;
      refl_q      <= refl_d;
      stuck_q     <= stuck_d;
      scan_addr_q <= scan_addr_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
      if (ram_we) begin
        written_q[ram_waddr] <= 1'b1;
      end
      if (ram_re) begin
        rd_idx_q     <= ram_raddr;
        rd_written_q <= written_q[ram_raddr];
      end
    end
  end

  // input beat and result payload
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      kind_q     <= kind_i;
      slot_q     <= slot_i;
      present_q  <= present_i;
      runnable_q <= runnable_i;
      prio_q     <= priority_req_i;
      cnt_q      <= counter_i;
    end
    if (out_load) begin
      out_slot_q  <= OUT_SLOT_W'(cur_q);
      out_cnt_q   <= ent_rd.cnt;
      out_sw_q    <= sw_q;
      out_sched_q <= sched_q;
      out_refl_q  <= refl_q;
      out_stuck_q <= stuck_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign current_slot_o    = out_slot_q;
  assign current_counter_o = out_cnt_q;
  assign switched_o        = out_sw_q;
  assign scheduled_o       = out_sched_q;
  assign refilled_o        = out_refl_q;
  assign stuck_o           = out_stuck_q;

  // a read and a write never meet on one slot in the same cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
    else $error("slot memory read and write collide");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_RPT))
    else $error("result raised outside the report step");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && stuck_o) |-> (refilled_o && scheduled_o))
    else $error("stuck without refill");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (switched_o || refilled_o)) |-> scheduled_o)
    else $error("switch or refill without a scheduling decision");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(cur_q) < TASK_SLOTS)
    else $error("current slot out of range");

endmodule
